// File: hw/rtl/fexm_pkg.sv
// Package: constants and binary32 arithmetic helpers for the expm1 pipeline.
`timescale 1ns / 1ps
package fexm_pkg;

  localparam int unsigned NUM_STAGES = 15;

  localparam logic [31:0] X_FLOOR    = 32'hC18AA123;
  localparam logic [31:0] MAGIC_BIAS = 32'h4A4001FC;
  localparam logic [31:0] NEG_MAGIC  = 32'hCA4001FC;
  localparam logic [31:0] LOG2E      = 32'h3FB8AA3B;
  localparam logic [31:0] NEG_LN2_HI = 32'hBF317200;
  localparam logic [31:0] NEG_LN2_LO = 32'hB5BFBE8E;
  localparam logic [31:0] COEF_C4    = 32'h3D2AA7CD;
  localparam logic [31:0] COEF_C3    = 32'h3E2AB841;
  localparam logic [31:0] COEF_C2    = 32'h3F000001;
  localparam logic [31:0] NEG_ONE    = 32'hBF800000;
  localparam logic [31:0] QNAN       = 32'h7FC00000;
  localparam logic [31:0] DEF_NAN    = 32'hFFC00000;
  localparam logic [31:0] QUIET_BIT  = 32'h00400000;

  // 2^(k/4) for k = 0..3
  localparam logic [31:0] FRAC_TBL [4] = '{
    32'h3F800000, 32'h3F9837F0, 32'h3FB504F3, 32'h3FD744FD
  };

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // Leading zero count of a nonzero 48-bit word
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Round to nearest even and pack; m has its leading one at bit 47
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [10:0] e,
                                             input logic [47:0] m);
    logic [5:0]  sh;
    logic [47:0] ms;
    logic        stk;
    logic        inc;
    logic [7:0]  ee;
    logic [31:0] r;
    sh  = 6'd0;
    ms  = m;
    stk = 1'b0;
    ee  = 8'd0;
    if (e > 11'sd254) begin
      r = {sgn, 8'hFF, 23'd0};
    end else begin
      if (e < 11'sd1) begin
        // subnormal result: denormalize with sticky
        sh  = (e < -11'sd62) ? 6'd63 : 6'(11'sd1 - e);
        ms  = m >> sh;
        stk = ((ms << sh) != m);
        ee  = 8'd0;
      end else begin
        ee  = e[7:0];
      end
      inc = ms[23] & ((|ms[22:0]) | stk | ms[24]);
      r   = {sgn, ee, ms[46:24]} + {31'd0, inc};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        an, bn, ai, bi, az, bz, sgn;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic signed [10:0] e;
    logic [31:0] r;
    an  = is_nan(a);
    bn  = is_nan(b);
    ai  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    bi  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    az  = (a[30:0] == 31'd0);
    bz  = (b[30:0] == 31'd0);
    sgn = a[31] ^ b[31];
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma  = {a[30:23] != 8'd0, a[22:0]};
    mb  = {b[30:23] != 8'd0, b[22:0]};
    p   = {24'd0, ma} * {24'd0, mb};
    lz  = lzc48(p);
    e   = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126 - $signed({5'd0, lz});
    if (an || bn || (ai && bz) || (bi && az)) begin
      r = QNAN;
    end else if (ai || bi) begin
      r = {sgn, 8'hFF, 23'd0};
    end else if (az || bz) begin
      r = {sgn, 31'd0};
    end else begin
      r = round_pack(sgn, e, p << lz);
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        ai, bi;
    logic [31:0] big, sml, r;
    logic [7:0]  ebig, esml, d;
    logic [26:0] mbx, msx, msh;
    logic        stk;
    logic [27:0] sum;
    logic [5:0]  lz;
    logic signed [10:0] e;
    ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = ebig - esml;
    mbx  = {big[30:23] != 8'd0, big[22:0], 3'b000};
    msx  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    msh  = msx >> d;
    stk  = ((msh << d) != msx);
    msh  = msh | {26'd0, stk};
    if (big[31] ^ sml[31]) sum = {1'b0, mbx} - {1'b0, msh};
    else                   sum = {1'b0, mbx} + {1'b0, msh};
    lz = lzc48({sum, 20'd0});
    e  = $signed({3'd0, ebig}) + 11'sd1 - $signed({5'd0, lz});
    if (is_nan(a) || is_nan(b) || (ai && bi && (a[31] != b[31]))) begin
      r = QNAN;
    end else if (ai) begin
      r = a;
    end else if (bi) begin
      r = b;
    end else if (sum == 28'd0) begin
      r = {big[31] & sml[31], 31'd0};
    end else begin
      r = round_pack(big[31], e, {sum, 20'd0} << lz);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/fexm_ifs.sv
// Interfaces: request channel and result channel of the expm1 pipeline.
`timescale 1ns / 1ps
interface fexm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  logic        last_in;
  modport source (output valid, output x_bits, output last_in, input ready);
  modport sink (input valid, input x_bits, input last_in, output ready);
endinterface

interface fexm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] y_bits;
  logic        last_out;
  modport source (output valid, output y_bits, output last_out, input ready);
  modport sink (input valid, input y_bits, input last_out, output ready);
endinterface

// File: hw/rtl/fexm_fmul.sv
// Registered binary32 multiplier stage.
`timescale 1ns / 1ps
module fexm_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);
  import fexm_pkg::*;

  logic [31:0] y_q;

  // product, rounded to nearest even
  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= fp_mul(a_i, b_i);
  end

  assign y_o = y_q;
endmodule

// File: hw/rtl/fexm_fadd.sv
// Registered binary32 adder stage.
`timescale 1ns / 1ps
module fexm_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);
  import fexm_pkg::*;

  logic [31:0] y_q;

  // sum, rounded to nearest even
  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= fp_add(a_i, b_i);
  end

  assign y_o = y_q;
endmodule

// File: hw/rtl/float_expm1_negative_unit.sv
// Throughput: one request per cycle while the output is not stalled; each pipeline stage holds one request.
// Backpressure: the whole pipeline holds while the output result is not taken.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
module float_expm1_negative_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  fexm_in_if.sink     in_i,
  fexm_out_if.source  out_o
);
  import fexm_pkg::*;

  logic en;
  logic [NUM_STAGES-1:0] vld_q;
  logic                  last_q [NUM_STAGES];
  logic                  ovr_q  [NUM_STAGES];
  logic [31:0]           ovb_q  [NUM_STAGES];

  logic [31:0] xin, xclamp;
  logic [31:0] x0_q, x1_q, x2_q, x3_q, x4_q;
  logic [31:0] s4_q, s5_q, s6_q, a2_5_q;
  logic [31:0] t7_q, t8_q, t9_q, t10_q;
  logic [31:0] ts8_q, ts9_q, ts10_q, ts11_q, ts12_q;
  logic [31:0] sm8_q, sm9_q, sm10_q, sm11_q, sm12_q, sm13_q;
  logic [31:0] y_q, fsum;

  logic [31:0] n1_w, n2_w, s3_w, nm3_w, a1_4_w, a2_4_w, t5_w, t6_w;
  logic [31:0] p7_w, ts7_w, sm7_w, p8_w, p9_w, p10_w, p11_w, a12_w, p13_w;

  // pipeline advances unless the output holds an untaken result
  assign en         = !vld_q[NUM_STAGES-1] || out_o.ready;
  assign in_i.ready = en;

  // input clamp at the saturation cutoff
  assign xin    = in_i.x_bits;
  assign xclamp = (xin[31] && (xin[30:0] > X_FLOOR[30:0])) ? X_FLOOR : xin;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_i.valid};
    end
  end

  // side data travelling with each item
  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q[0] <= in_i.last_in;
      ovr_q[0]  <= is_nan(xin);
      ovb_q[0]  <= xin | QUIET_BIT;
      for (int i = 1; i < NUM_STAGES; i++) begin
        last_q[i] <= last_q[i-1];
        ovr_q[i]  <= ovr_q[i-1];
        ovb_q[i]  <= ovb_q[i-1];
      end
      x0_q   <= xclamp;
      x1_q   <= x0_q;
      x2_q   <= x1_q;
      x3_q   <= x2_q;
      x4_q   <= x3_q;
      s4_q   <= s3_w;
      s5_q   <= s4_q;
      s6_q   <= s5_q;
      a2_5_q <= a2_4_w;
      t7_q   <= t6_w;
      t8_q   <= t7_q;
      t9_q   <= t8_q;
      t10_q  <= t9_q;
      ts8_q  <= ts7_w;
      ts9_q  <= ts8_q;
      ts10_q <= ts9_q;
      ts11_q <= ts10_q;
      ts12_q <= ts11_q;
      sm8_q  <= sm7_w;
      sm9_q  <= sm8_q;
      sm10_q <= sm9_q;
      sm11_q <= sm10_q;
      sm12_q <= sm11_q;
      sm13_q <= sm12_q;
    end
  end

  // range reduction: n = round4(x*log2e), scale s, t = x - n*ln2
  fexm_fmul u_n1  (.clk_i, .en_i(en), .a_i(x0_q),   .b_i(LOG2E),      .y_o(n1_w));
  fexm_fadd u_n2  (.clk_i, .en_i(en), .a_i(n1_w),   .b_i(MAGIC_BIAS), .y_o(n2_w));
  fexm_fmul u_s3  (.clk_i, .en_i(en), .a_i(FRAC_TBL[n2_w[1:0]]),
                   .b_i({n2_w[10:2], 23'd0}), .y_o(s3_w));
  fexm_fadd u_nm3 (.clk_i, .en_i(en), .a_i(n2_w),   .b_i(NEG_MAGIC),  .y_o(nm3_w));
  fexm_fmul u_a14 (.clk_i, .en_i(en), .a_i(nm3_w),  .b_i(NEG_LN2_HI), .y_o(a1_4_w));
  fexm_fmul u_a24 (.clk_i, .en_i(en), .a_i(nm3_w),  .b_i(NEG_LN2_LO), .y_o(a2_4_w));
  fexm_fadd u_t5  (.clk_i, .en_i(en), .a_i(a1_4_w), .b_i(x4_q),       .y_o(t5_w));
  fexm_fadd u_t6  (.clk_i, .en_i(en), .a_i(a2_5_q), .b_i(t5_w),       .y_o(t6_w));

  // polynomial and reconstruction
  fexm_fmul u_p7  (.clk_i, .en_i(en), .a_i(COEF_C4), .b_i(t6_w),      .y_o(p7_w));
  fexm_fmul u_ts7 (.clk_i, .en_i(en), .a_i(t6_w),    .b_i(s6_q),      .y_o(ts7_w));
  fexm_fadd u_sm7 (.clk_i, .en_i(en), .a_i(s6_q),    .b_i(NEG_ONE),   .y_o(sm7_w));
  fexm_fadd u_p8  (.clk_i, .en_i(en), .a_i(p7_w),    .b_i(COEF_C3),   .y_o(p8_w));
  fexm_fmul u_p9  (.clk_i, .en_i(en), .a_i(p8_w),    .b_i(t8_q),      .y_o(p9_w));
  fexm_fadd u_p10 (.clk_i, .en_i(en), .a_i(p9_w),    .b_i(COEF_C2),   .y_o(p10_w));
  fexm_fmul u_p11 (.clk_i, .en_i(en), .a_i(p10_w),   .b_i(t10_q),     .y_o(p11_w));
  fexm_fmul u_a12 (.clk_i, .en_i(en), .a_i(p11_w),   .b_i(ts11_q),    .y_o(a12_w));
  fexm_fadd u_p13 (.clk_i, .en_i(en), .a_i(a12_w),   .b_i(ts12_q),    .y_o(p13_w));

  // final add, NaN override
  assign fsum = fp_add(p13_w, sm13_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ovr_q[NUM_STAGES-2]) y_q <= ovb_q[NUM_STAGES-2];
      else if (is_nan(fsum))   y_q <= DEF_NAN;
      else                     y_q <= fsum;
    end
  end

  assign out_o.valid    = vld_q[NUM_STAGES-1];
  assign out_o.y_bits   = y_q;
  assign out_o.last_out = last_q[NUM_STAGES-1];

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted request did not enter stage 0");

  // a held result keeps its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(y_q) && $stable(vld_q))
    else $error("pipeline moved while output stalled");

  // only the default NaN or a quieted input NaN leaves the block
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && is_nan(y_q) |->
      (y_q == DEF_NAN) || (ovr_q[NUM_STAGES-1] && (y_q == ovb_q[NUM_STAGES-1])))
    else $error("unexpected NaN encoding on output");
endmodule
